// File: hw/rtl/ssd_pkg.sv
// ssd_pkg: widths, latencies, codes and split-multiply helpers for the segment distance pipeline
// no dependencies; used by ssd_frac_div, ssd_isqrt and the top level
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int COORD_W    = 32;
  localparam int PARAM_BITS = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int WIDE_W     = 2 * DOT_W + 4;
  localparam int REM_W      = WIDE_W + 1;
  localparam int SC_W       = PARAM_BITS + 1;
  localparam int WS_W       = DIFF_W + PARAM_BITS;
  localparam int MP_W       = DIFF_W + SC_W + 1;
  localparam int COMP_W     = MP_W + 1;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int X_W        = SUM_W - 2 * PARAM_BITS;
  localparam int DIST_W     = COORD_W + 1;
  localparam int SQ_REM_W   = X_W + 1;
  localparam int HALF_W     = DOT_W / 2;
  localparam int MUL_W      = 2 * DOT_W;

  localparam int PRE_LAT  = 8;
  localparam int DIV_LAT  = PARAM_BITS + 1;
  localparam int SQRT_LAT = DIST_W;
  localparam int UVW_DLY  = PRE_LAT + DIV_LAT - 1;
  localparam int NSTG     = PRE_LAT + DIV_LAT + 5 + SQRT_LAT;

  localparam logic [1:0] DIV_CALC = 2'd0;
  localparam logic [1:0] DIV_ZERO = 2'd1;
  localparam logic [1:0] DIV_ONE  = 2'd2;

  typedef logic [2:0][DIFF_W-1:0] vec3_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    vec3_t u;
    vec3_t v;
    vec3_t w;
  } geom_t;

  // partial products of a wide signed multiply split into halves
  typedef struct packed {
    logic [2*HALF_W-1:0] ll;
    logic [2*HALF_W:0]   lh;
    logic [2*HALF_W:0]   hl;
    logic [2*HALF_W-1:0] hh;
  } mul_pp_t;

  function automatic mul_pp_t mul_parts(input logic signed [DOT_W-1:0] x,
                                        input logic signed [DOT_W-1:0] y);
    mul_pp_t p;
    p.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
    p.lh = $signed({1'b0, x[HALF_W-1:0]}) * $signed(y[DOT_W-1:HALF_W]);
    p.hl = $signed(x[DOT_W-1:HALF_W]) * $signed({1'b0, y[HALF_W-1:0]});
    p.hh = $signed(x[DOT_W-1:HALF_W]) * $signed(y[DOT_W-1:HALF_W]);
    return p;
  endfunction

  function automatic logic signed [MUL_W-1:0] mul_join(input mul_pp_t p);
    return MUL_W'(p.ll)
         + (MUL_W'($signed(p.lh)) <<< HALF_W)
         + (MUL_W'($signed(p.hl)) <<< HALF_W)
         + (MUL_W'($signed(p.hh)) <<< (2 * HALF_W));
  endfunction

endpackage

// File: hw/rtl/ssd_frac_div.sv
// ssd_frac_div: pipelined restoring divider, floor(n * 2^32 / den) clamped to [0, 2^32]
// one quotient bit per stage; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_frac_div (
  input  logic                       clk,
  input  logic                       en,
  input  ssd_pkg::wide_t             n,
  input  ssd_pkg::wide_t             den,
  output logic [ssd_pkg::SC_W-1:0]   q
);
  import ssd_pkg::*;

  logic [1:0]            mode [DIV_LAT];
  logic [REM_W-1:0]      rem  [DIV_LAT];
  logic [WIDE_W-1:0]     dv   [DIV_LAT];
  logic [PARAM_BITS-1:0] qq   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      if (n <= 0 || den <= 0) begin
        mode[0] <= DIV_ZERO;
      end else if (n >= den) begin
        mode[0] <= DIV_ONE;
      end else begin
        mode[0] <= DIV_CALC;
      end
      rem[0] <= REM_W'($unsigned(n));
      dv[0]  <= $unsigned(den);
      qq[0]  <= '0;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [REM_W-1:0] r2;
    logic             ge;
    assign r2 = {rem[k-1][REM_W-2:0], 1'b0};
    assign ge = r2 >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? r2 - {1'b0, dv[k-1]} : r2;
        qq[k]   <= {qq[k-1][PARAM_BITS-2:0], ge};
        mode[k] <= mode[k-1];
        dv[k]   <= dv[k-1];
      end
    end
  end

  always_comb begin
    case (mode[DIV_LAT-1])
      DIV_ONE:  q = SC_W'(1) << PARAM_BITS;
      DIV_ZERO: q = '0;
      default:  q = {1'b0, qq[DIV_LAT-1]};
    endcase
  end

endmodule

// File: hw/rtl/ssd_isqrt.sv
// ssd_isqrt: pipelined integer square root, one result bit per stage
// saturates to all ones in the result width; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssd_pkg::X_W-1:0]     x,
  output logic [ssd_pkg::DIST_W-1:0]  root
);
  import ssd_pkg::*;

  logic [SQ_REM_W-1:0] rem [SQRT_LAT];
  logic [DIST_W-1:0]   r   [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_bit
    localparam int B = DIST_W - 1 - k;
    logic [SQ_REM_W-1:0] prem;
    logic [DIST_W-1:0]   pr;
    logic [SQ_REM_W-1:0] t;
    if (k == 0) begin : g_first
      assign prem = SQ_REM_W'(x);
      assign pr   = '0;
    end else begin : g_next
      assign prem = rem[k-1];
      assign pr   = r[k-1];
    end
    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign t = (SQ_REM_W'(pr) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (t <= prem) begin
          rem[k] <= prem - t;
          r[k]   <= pr | (DIST_W'(1) << B);
        end else begin
          rem[k] <= prem;
          r[k]   <= pr;
        end
      end
    end
  end

  assign root = r[SQRT_LAT-1];

endmodule

// File: hw/rtl/segment_segment_distance_3d_top.sv
// segment_segment_distance_3d_top: shortest distance between two 3d segments
// depends on ssd_pkg, ssd_frac_div, ssd_isqrt
//
//   channel | signals                              | word
//   in      | in_valid, in_stall, s1_*..k2_*       | two segments, 12 x signed q16.16
//   out     | out_valid, out_stall, distance       | distance, unsigned q17.16
//
// one word enters per cycle while in_stall is low; the pipeline has 8 setup stages, a 33-stage
// divider pair (an input stage, then one quotient bit per stage), 5 closest-point stages and a
// 33-stage square root (one bit per stage)
// rst clears the valid bits only; payload registers are not reset
// a held output stalls the whole pipeline; in_stall is high while it is held
`timescale 1ns / 1ps

module segment_segment_distance_3d_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ssd_pkg::DIST_W-1:0]         distance
);
  import ssd_pkg::*;

  logic            en;
  logic [NSTG-1:0] vld;

  assign en        = !(vld[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: edge and offset vectors
  geom_t g1;
  always_ff @(posedge clk) begin
    if (en) begin
      g1.u[0] <= DIFF_W'(s2_x) - DIFF_W'(s1_x);
      g1.u[1] <= DIFF_W'(s2_y) - DIFF_W'(s1_y);
      g1.u[2] <= DIFF_W'(s2_z) - DIFF_W'(s1_z);
      g1.v[0] <= DIFF_W'(k2_x) - DIFF_W'(k1_x);
      g1.v[1] <= DIFF_W'(k2_y) - DIFF_W'(k1_y);
      g1.v[2] <= DIFF_W'(k2_z) - DIFF_W'(k1_z);
      g1.w[0] <= DIFF_W'(s1_x) - DIFF_W'(k1_x);
      g1.w[1] <= DIFF_W'(s1_y) - DIFF_W'(k1_y);
      g1.w[2] <= DIFF_W'(s1_z) - DIFF_W'(k1_z);
    end
  end

  // stage 2: per-axis products
  logic signed [PROD_W-1:0] puu [3];
  logic signed [PROD_W-1:0] puv [3];
  logic signed [PROD_W-1:0] pvv [3];
  logic signed [PROD_W-1:0] puw [3];
  logic signed [PROD_W-1:0] pvw [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        puu[j] <= $signed(g1.u[j]) * $signed(g1.u[j]);
        puv[j] <= $signed(g1.u[j]) * $signed(g1.v[j]);
        pvv[j] <= $signed(g1.v[j]) * $signed(g1.v[j]);
        puw[j] <= $signed(g1.u[j]) * $signed(g1.w[j]);
        pvw[j] <= $signed(g1.v[j]) * $signed(g1.w[j]);
      end
    end
  end

  // stage 3: dot products
  logic signed [DOT_W-1:0] a3, b3, c3, d3, e3;
  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= DOT_W'(puu[0]) + DOT_W'(puu[1]) + DOT_W'(puu[2]);
      b3 <= DOT_W'(puv[0]) + DOT_W'(puv[1]) + DOT_W'(puv[2]);
      c3 <= DOT_W'(pvv[0]) + DOT_W'(pvv[1]) + DOT_W'(pvv[2]);
      d3 <= DOT_W'(puw[0]) + DOT_W'(puw[1]) + DOT_W'(puw[2]);
      e3 <= DOT_W'(pvw[0]) + DOT_W'(pvw[1]) + DOT_W'(pvw[2]);
    end
  end

  // stage 4: half-width partial products of the dot cross terms
  mul_pp_t ac_pp, bb_pp, be_pp, cd_pp, ae_pp, bd_pp;
  logic signed [DOT_W-1:0] a4p, b4p, c4p, d4p, e4p;
  always_ff @(posedge clk) begin
    if (en) begin
      ac_pp <= mul_parts(a3, c3);
      bb_pp <= mul_parts(b3, b3);
      be_pp <= mul_parts(b3, e3);
      cd_pp <= mul_parts(c3, d3);
      ae_pp <= mul_parts(a3, e3);
      bd_pp <= mul_parts(b3, d3);
      a4p   <= a3;
      b4p   <= b3;
      c4p   <= c3;
      d4p   <= d3;
      e4p   <= e3;
    end
  end

  // stage 5: cross products of the dots
  logic signed [2*DOT_W-1:0] ac4, bb4, be4, cd4, ae4, bd4;
  logic signed [DOT_W-1:0]   a4, b4, c4, d4, e4;
  always_ff @(posedge clk) begin
    if (en) begin
      ac4 <= mul_join(ac_pp);
      bb4 <= mul_join(bb_pp);
      be4 <= mul_join(be_pp);
      cd4 <= mul_join(cd_pp);
      ae4 <= mul_join(ae_pp);
      bd4 <= mul_join(bd_pp);
      a4  <= a4p;
      b4  <= b4p;
      c4  <= c4p;
      d4  <= d4p;
      e4  <= e4p;
    end
  end

  // stage 6: determinant and raw numerators
  wide_t dt5, sn5, tn5;
  logic signed [DOT_W-1:0] a5, b5, c5, d5, e5;
  always_ff @(posedge clk) begin
    if (en) begin
      dt5 <= WIDE_W'(ac4) - WIDE_W'(bb4);
      sn5 <= WIDE_W'(be4) - WIDE_W'(cd4);
      tn5 <= WIDE_W'(ae4) - WIDE_W'(bd4);
      a5  <= a4;
      b5  <= b4;
      c5  <= c4;
      d5  <= d4;
      e5  <= e4;
    end
  end

  // stage 7: parallel case and clamp of the s parameter
  wide_t sn6_next, sd6_next, tn6_next, td6_next;
  always_comb begin
    if (dt5 <= 0) begin
      sn6_next = '0;
      sd6_next = WIDE_W'(1);
      tn6_next = WIDE_W'(e5);
      td6_next = WIDE_W'(c5);
    end else begin
      sn6_next = sn5;
      sd6_next = dt5;
      tn6_next = tn5;
      td6_next = dt5;
      if (sn5 < 0) begin
        sn6_next = '0;
        tn6_next = WIDE_W'(e5);
        td6_next = WIDE_W'(c5);
      end else if (sn5 > dt5) begin
        sn6_next = dt5;
        tn6_next = WIDE_W'(e5) + WIDE_W'(b5);
        td6_next = WIDE_W'(c5);
      end
    end
  end

  wide_t sn6, sd6, tn6, td6;
  logic signed [DOT_W-1:0] a6, b6, d6;
  always_ff @(posedge clk) begin
    if (en) begin
      sn6 <= sn6_next;
      sd6 <= sd6_next;
      tn6 <= tn6_next;
      td6 <= td6_next;
      a6  <= a5;
      b6  <= b5;
      d6  <= d5;
    end
  end

  // stage 8: clamp of the t parameter, s recomputed against the k ends
  wide_t sn7_next, sd7_next, tn7_next, negd, mb, sel;
  always_comb begin
    negd     = -WIDE_W'(d6);
    mb       = negd + WIDE_W'(b6);
    sn7_next = sn6;
    sd7_next = sd6;
    tn7_next = tn6;
    sel      = negd;
    if (tn6 > td6) begin
      sel = mb;
    end
    if (tn6 < 0 || tn6 > td6) begin
      tn7_next = (tn6 < 0) ? '0 : td6;
      if (sel < 0) begin
        sn7_next = '0;
      end else if (sel > WIDE_W'(a6)) begin
        sn7_next = sd6;
      end else begin
        sn7_next = sel;
        sd7_next = WIDE_W'(a6);
      end
    end
  end

  wide_t sn7, sd7, tn7, td7;
  always_ff @(posedge clk) begin
    if (en) begin
      sn7 <= sn7_next;
      sd7 <= sd7_next;
      tn7 <= tn7_next;
      td7 <= td6;
    end
  end

  // parameter divisions
  logic [SC_W-1:0] sc, tc;

  ssd_frac_div u_div_s (
    .clk (clk),
    .en  (en),
    .n   (sn7),
    .den (sd7),
    .q   (sc)
  );

  ssd_frac_div u_div_t (
    .clk (clk),
    .en  (en),
    .n   (tn7),
    .den (td7),
    .q   (tc)
  );

  // vectors ride alongside the setup and divider stages
  geom_t gdl [UVW_DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      gdl[0] <= g1;
      for (int k = 1; k < UVW_DLY; k++) begin
        gdl[k] <= gdl[k-1];
      end
    end
  end

  geom_t gq;
  assign gq = gdl[UVW_DLY-1];

  // closest-point difference: w * 2^32 + u * sc - v * tc
  logic signed [WS_W-1:0] ws [3];
  logic signed [MP_W-1:0] mu [3];
  logic signed [MP_W-1:0] mv [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ws[j] <= $signed({gq.w[j], {PARAM_BITS{1'b0}}});
        mu[j] <= $signed(gq.u[j]) * $signed({1'b0, sc});
        mv[j] <= $signed(gq.v[j]) * $signed({1'b0, tc});
      end
    end
  end

  logic signed [COMP_W-1:0] comp [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        comp[j] <= COMP_W'(ws[j]) + COMP_W'(mu[j]) - COMP_W'(mv[j]);
      end
    end
  end

  // squares split over two stages
  mul_pp_t sq_pp [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq_pp[j] <= mul_parts(comp[j], comp[j]);
      end
    end
  end

  logic [SQ_W-1:0] sq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq[j] <= $unsigned(mul_join(sq_pp[j]));
      end
    end
  end

  logic [SUM_W-1:0] sum;
  logic [X_W-1:0]   xs;
  assign sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      xs <= sum[SUM_W-1:2*PARAM_BITS];
    end
  end

  ssd_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (xs),
    .root (distance)
  );

endmodule

// File: dv/segment_distance_checker.sv
// segment_distance_checker: watches both channels, predicts each distance and compares
// depends on ssd_pkg for the port widths
`timescale 1ns / 1ps

module segment_distance_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] s1_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] s2_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] k1_z,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_x,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_y,
  input  logic signed [ssd_pkg::COORD_W-1:0] k2_z,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [ssd_pkg::DIST_W-1:0]         distance,
  output int                                 errors,
  output int                                 pending
);
  import ssd_pkg::*;

  typedef logic signed [255:0] big_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  logic [DIST_W-1:0] dist_q[$];

  function automatic big_t param_frac(big_t n, big_t den);
    if (n <= 0 || den <= 0) return 0;
    if (n >= den) return big_t'(1) <<< PARAM_BITS;
    return (n <<< PARAM_BITS) / den;
  endfunction

  function automatic logic [DIST_W-1:0] seg_distance(input coord_t c[12]);
    big_t u[3], v[3], w[3];
    big_t a, b, cc, d, e, dd, sn, sd, tn, td, negd, m, sc, tc, comp, sum, x, cand;
    logic [DIST_W-1:0] r;
    for (int j = 0; j < 3; j++) begin
      u[j] = big_t'(c[3 + j]) - big_t'(c[j]);
      v[j] = big_t'(c[9 + j]) - big_t'(c[6 + j]);
      w[j] = big_t'(c[j]) - big_t'(c[6 + j]);
    end
    a = 0; b = 0; cc = 0; d = 0; e = 0;
    for (int j = 0; j < 3; j++) begin
      a += u[j] * u[j];
      b += u[j] * v[j];
      cc += v[j] * v[j];
      d += u[j] * w[j];
      e += v[j] * w[j];
    end
    dd = a * cc - b * b;
    if (dd <= 0) begin
      sn = 0; sd = 1; tn = e; td = cc;
    end else begin
      sn = b * e - cc * d;
      tn = a * e - b * d;
      sd = dd; td = dd;
      if (sn < 0) begin
        sn = 0; tn = e; td = cc;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = cc;
      end
    end
    negd = -d;
    if (tn < 0) begin
      tn = 0;
      if (negd < 0) sn = 0;
      else if (negd > a) sn = sd;
      else begin
        sn = negd; sd = a;
      end
    end else if (tn > td) begin
      m = negd + b;
      tn = td;
      if (m < 0) sn = 0;
      else if (m > a) sn = sd;
      else begin
        sn = m; sd = a;
      end
    end
    sc = param_frac(sn, sd);
    tc = param_frac(tn, td);
    sum = 0;
    for (int j = 0; j < 3; j++) begin
      comp = (w[j] <<< PARAM_BITS) + u[j] * sc - v[j] * tc;
      sum += comp * comp;
    end
    x = sum >>> (2 * PARAM_BITS);
    r = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      cand = big_t'(r) | (big_t'(1) <<< i);
      if (cand * cand <= x) r = cand[DIST_W-1:0];
    end
    return r;
  endfunction

  coord_t word[12];
  assign word = '{s1_x, s1_y, s1_z, s2_x, s2_y, s2_z, k1_x, k1_y, k1_z, k2_x, k2_y, k2_z};

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      pending = 0;
    end else begin
      if (in_valid && !in_stall) dist_q.push_back(seg_distance(word));
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $display("%0t: unexpected distance %h", $time, distance);
          errors++;
        end else if (distance !== dist_q[0]) begin
          $display("%0t: distance expected %h actual %h", $time, dist_q[0], distance);
          errors++;
          void'(dist_q.pop_front());
        end else begin
          void'(dist_q.pop_front());
        end
      end
      pending = dist_q.size();
    end
  end

endmodule

// File: dv/tb_segment_segment_distance_3d_top.sv
// tb_segment_segment_distance_3d_top: stimulus and verdict for the segment distance block
// depends on ssd_pkg, segment_segment_distance_3d_top and segment_distance_checker
`timescale 1ns / 1ps

module tb_segment_segment_distance_3d_top;
  import ssd_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [DIST_W-1:0] distance;
  coord_t crd[12] = '{default: '0};
  int errors, pending;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_segment_distance_3d_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .s1_x(crd[0]), .s1_y(crd[1]), .s1_z(crd[2]),
    .s2_x(crd[3]), .s2_y(crd[4]), .s2_z(crd[5]),
    .k1_x(crd[6]), .k1_y(crd[7]), .k1_z(crd[8]),
    .k2_x(crd[9]), .k2_y(crd[10]), .k2_z(crd[11]),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance)
  );

  segment_distance_checker i_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .s1_x(crd[0]), .s1_y(crd[1]), .s1_z(crd[2]),
    .s2_x(crd[3]), .s2_y(crd[4]), .s2_z(crd[5]),
    .k1_x(crd[6]), .k1_y(crd[7]), .k1_z(crd[8]),
    .k2_x(crd[9]), .k2_y(crd[10]), .k2_z(crd[11]),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .errors(errors), .pending(pending)
  );

  initial begin
    #2ms;
    $display("tb_segment_segment_distance_3d_top NOT OK");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
        @(posedge clk);
      end
    end
  end

  // offer one word and hold it until taken, with a random gap before it unless calm is set
  task automatic send_segments(input coord_t c[12]);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 12; i++) crd[i] <= c[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      default: return coord_t'($signed($urandom_range(0, 2 ** 13)) - 2 ** 12) <<< 16;
    endcase
  endfunction

  task automatic send_random();
    coord_t c[12];
    int mode, shape;
    mode = $urandom_range(0, 2);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) c[i] = rnd_coord(mode);
    case (shape)
      0: for (int j = 0; j < 3; j++) c[9 + j] = c[6 + j] + (c[3 + j] - c[j]);  // parallel
      1: for (int j = 0; j < 3; j++) c[3 + j] = c[j];                          // s is a point
      2: for (int j = 0; j < 3; j++) c[9 + j] = c[6 + j];                      // k is a point
      3: for (int j = 0; j < 3; j++) c[6 + j] = c[3 + j];                      // shared end
      4: for (int j = 0; j < 3; j++) c[9 + j] = c[6 + j] - (c[3 + j] - c[j]);  // antiparallel
      default: ;
    endcase
    send_segments(c);
  endtask

  initial begin
    coord_t z[12], c[12];
    coord_t mx, mn;
    mx = coord_t'(32'h7fffffff);
    mn = coord_t'(32'h80000000);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 12; i++) z[i] = '0;
    calm = 1'b1;
    send_segments(z);
    // extremes: every coordinate at max, at min, and opposite corners
    for (int i = 0; i < 12; i++) c[i] = mx;
    send_segments(c);
    for (int i = 0; i < 12; i++) c[i] = mn;
    send_segments(c);
    for (int i = 0; i < 12; i++) c[i] = (i % 6 < 3) ? mn : mx;
    send_segments(c);
    for (int i = 0; i < 12; i++) c[i] = (i < 6) ? mn : mx;
    send_segments(c);
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? mn : mx;
    send_segments(c);
    calm = 1'b0;
    // crossing, parallel, point, and clamped-end geometries in whole units and in raw LSB steps
    c = '{0, 0, 0, 2 << 16, 0, 0, 1 << 16, -(1 << 16), 1 << 16, 1 << 16, 1 << 16, 1 << 16};
    send_segments(c);
    c = '{0, 0, 0, 4 << 16, 0, 0, 0, 1 << 16, 0, 4 << 16, 1 << 16, 0};
    send_segments(c);
    c = '{0, 0, 0, 4 << 16, 0, 0, 4 << 16, 3 << 16, 0, 0, 3 << 16, 0};
    send_segments(c);
    c = '{5, 5, 5, 5, 5, 5, 0, 0, 0, 10, 10, 10};
    send_segments(c);
    c = '{1, 2, 3, 1, 2, 3, 7, 8, 9, 7, 8, 9};
    send_segments(c);
    c = '{0, 0, 0, 1 << 16, 0, 0, 5 << 16, -(1 << 16), 1 << 16, 5 << 16, 1 << 16, 1 << 16};
    send_segments(c);
    c = '{0, 0, 0, 1 << 16, 0, 0, -(5 << 16), -(1 << 16), 0, -(5 << 16), 1 << 16, 0};
    send_segments(c);
    c = '{0, 0, 0, 4 << 16, 0, 0, 2 << 16, 5 << 16, 0, 2 << 16, 9 << 16, 0};
    send_segments(c);
    c = '{0, 0, 0, 4 << 16, 0, 0, 2 << 16, 9 << 16, 0, 2 << 16, 5 << 16, 0};
    send_segments(c);
    c = '{0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 1, 0};
    send_segments(c);

    // sender pauses until the pipeline drains
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    for (int n = 0; n < 1250; n++) begin
      if (n == 200) hold_req = 1'b1;
      calm = (n >= 600 && n < 700);
      if (n == 900) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      send_random();
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_segment_segment_distance_3d_top OK");
    else
      $display("tb_segment_segment_distance_3d_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_frac_div.sv
hw/rtl/ssd_isqrt.sv
hw/rtl/segment_segment_distance_3d_top.sv
dv/segment_distance_checker.sv
dv/tb_segment_segment_distance_3d_top.sv
